FILE: rtl/has_pkg.sv
package has_pkg;

  localparam int SAMPLE_W      = 16;
  localparam int TAP_W         = 16;
  localparam int IMAG_W        = 35;
  localparam int PROD_W        = SAMPLE_W + TAP_W;
  localparam int NUM_TAPS      = 8;
  localparam int TAP_IDX_W     = $clog2(NUM_TAPS);
  localparam int FIR_ORDER_DEF = 7;
  localparam int DELAY_LEN_DEF = 4;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [TAP_W-1:0]    tap_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [IMAG_W-1:0]   acc_t;

endpackage

FILE: rtl/hilbert_analytic_signal.sv
// Path: an accepted word passes the input register, then the result register, where
// out_valid rises; a stall on the result side can hold it in the input register.
// Throughput: one word per cycle; in_ready stays high unless both stages hold words and
// the result side stalls. The eight tap multipliers work in parallel, combinationally.
// Reset (synchronous, rst_n low): clears taps, delay line, partial sums and both valid
// flags; the result payload registers are not reset.
module hilbert_analytic_signal #(
  parameter int FIR_ORDER = has_pkg::FIR_ORDER_DEF,
  parameter int DELAY_LEN = has_pkg::DELAY_LEN_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_we,
  input  logic [has_pkg::TAP_IDX_W-1:0]     cfg_index,
  input  logic [has_pkg::TAP_W-1:0]         cfg_wdata,
  // input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [has_pkg::SAMPLE_W-1:0] in_sample,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [has_pkg::SAMPLE_W-1:0] out_real_part,
  output logic signed [has_pkg::IMAG_W-1:0]   out_imag_part
);

  has_pkg::tap_t    tap_r [has_pkg::NUM_TAPS];
  has_pkg::sample_t dl_r  [DELAY_LEN];
  has_pkg::acc_t    ps_r  [FIR_ORDER];
  has_pkg::prod_t   prod  [FIR_ORDER+1];
  has_pkg::acc_t    ps_nxt [FIR_ORDER];
  has_pkg::acc_t    imag_nxt;

  logic             s1_valid_r;
  has_pkg::sample_t s1_sample_r;
  logic             s1_adv;
  logic             out_valid_r;
  has_pkg::sample_t out_real_r;
  has_pkg::acc_t    out_imag_r;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  // tap registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < has_pkg::NUM_TAPS; i++) tap_r[i] <= '0;
    end else if (cfg_we) begin
      tap_r[cfg_index] <= has_pkg::tap_t'(cfg_wdata);
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_sample_r <= in_sample;
    end
  end

  // tap products, all in parallel; widen both operands so the full product is kept
  for (genvar k = 0; k <= FIR_ORDER; k++) begin : g_prod
    assign prod[k] = has_pkg::prod_t'(tap_r[k]) * has_pkg::prod_t'(s1_sample_r);
  end

  // transposed FIR: shift partial sums one place toward the output
  for (genvar k = 0; k < FIR_ORDER; k++) begin : g_ps
    if (k == FIR_ORDER - 1) begin : g_last
      assign ps_nxt[k] = has_pkg::acc_t'(prod[k+1]);
    end else begin : g_mid
      assign ps_nxt[k] = has_pkg::acc_t'(prod[k+1]) + ps_r[k+1];
    end
  end

  assign imag_nxt = has_pkg::acc_t'(prod[0]) + ps_r[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < FIR_ORDER; i++) ps_r[i] <= '0;
      for (int i = 0; i < DELAY_LEN; i++) dl_r[i] <= '0;
    end else if (s1_adv) begin
      for (int i = 0; i < FIR_ORDER; i++) ps_r[i] <= ps_nxt[i];
      for (int i = 0; i < DELAY_LEN - 1; i++) dl_r[i] <= dl_r[i+1];
      dl_r[DELAY_LEN-1] <= s1_sample_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_real_r <= dl_r[0];
      out_imag_r <= imag_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_real_part = out_real_r;
  assign out_imag_part = out_imag_r;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid_r && !out_ready))
    else $error("input stalled while a stage has room");

  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("advanced word did not reach the result register");

  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_sample_r)))
    else $error("held input word lost or changed");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (!out_valid_r && !s1_valid_r))
    else $error("valid flags not cleared by reset");

endmodule
